FILE: sv/assert_macros.svh
// assertion macros for the speck rtl files
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/spk_pkg.sv
// shared types and constants for the speck 64/128 cipher
// no dependencies; used by the controller, datapath and top level
package spk_pkg;

  localparam int WORD_W     = 32;
  localparam int KEY_WORDS  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int KSEL_W     = 2;
  localparam int ROT_X      = 8;
  localparam int ROT_Y      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd3;

  // controller to datapath and round-key ram commands
  typedef struct packed {
    logic load_block;
    logic key_init;
    logic key_step;
    logic round_en;
    logic decrypt;
    logic rk_we;
  } cmd_t;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
    return {v[ROT_X-1:0], v[WORD_W-1:ROT_X]};
  endfunction

  function automatic logic [WORD_W-1:0] rol8(input logic [WORD_W-1:0] v);
    return {v[WORD_W-ROT_X-1:0], v[WORD_W-1:WORD_W-ROT_X]};
  endfunction

  function automatic logic [WORD_W-1:0] ror3(input logic [WORD_W-1:0] v);
    return {v[ROT_Y-1:0], v[WORD_W-1:ROT_Y]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-ROT_Y-1:0], v[WORD_W-1:WORD_W-ROT_Y]};
  endfunction

endpackage

FILE: sv/speck64_128_block_cipher.sv
// speck 64/128 block cipher, top level
// depends on spk_pkg, spk_ctrl, spk_datapath and spk_ram
//
// channel   handshake              payload
// ------    ---------------------  ----------------------------------------
// block in  start, busy            mode, word_low, word_high
// result    done (one-cycle pulse) result_low, result_high
// key cfg   cfg_valid, cfg_ready   cfg_index, cfg_data
//
// a block runs from start to the done pulse through the prefetch state,
// which primes the round-key ram read, then one round a cycle on the shared
// round unit. after a key write the next block first runs the schedule,
// one round key written to the ram each cycle. reset clears the key words
// and marks the round keys stale. busy drops in the cycle of the done
// pulse, so a new block may start there. the result is not held off by
// the receiver; cfg_ready is always high.
module speck64_128_block_cipher #(
  parameter int ROUND_COUNT = 27
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [spk_pkg::WORD_W-1:0]      word_low,
  input  logic [spk_pkg::WORD_W-1:0]      word_high,
  output logic                            done,
  output logic [spk_pkg::WORD_W-1:0]      result_low,
  output logic [spk_pkg::WORD_W-1:0]      result_high,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]      cfg_data
);

  localparam int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  spk_pkg::cmd_t               cmd;
  logic [AW-1:0]               step_idx;
  logic [AW-1:0]               rk_waddr;
  logic [AW-1:0]               rk_raddr;
  logic [spk_pkg::WORD_W-1:0]  rk_wdata;
  logic [spk_pkg::WORD_W-1:0]  rk_rdata;
  logic                        key_write;
  logic                        key_hit;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      spk_pkg::REG_KEY_WORD_0, spk_pkg::REG_KEY_WORD_1,
      spk_pkg::REG_KEY_WORD_2, spk_pkg::REG_KEY_WORD_3: key_hit = 1'b1;
      default: key_hit = 1'b0;
    endcase
  end

  assign key_write = cfg_valid && cfg_ready && key_hit;

  spk_ctrl #(
    .ROUND_COUNT (ROUND_COUNT),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .key_write (key_write),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .step_idx  (step_idx),
    .rk_waddr  (rk_waddr),
    .rk_raddr  (rk_raddr)
  );

  spk_datapath #(
    .ROUND_COUNT (ROUND_COUNT),
    .AW          (AW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .step_idx    (step_idx),
    .key_write   (key_write),
    .key_sel     (cfg_index[spk_pkg::KSEL_W-1:0]),
    .key_data    (cfg_data),
    .word_low    (word_low),
    .word_high   (word_high),
    .rk_rdata    (rk_rdata),
    .rk_wdata    (rk_wdata),
    .result_low  (result_low),
    .result_high (result_high)
  );

  spk_ram #(
    .WIDTH (spk_pkg::WORD_W),
    .DEPTH (ROUND_COUNT),
    .AW    (AW)
  ) u_round_keys (
    .clk   (clk),
    .we    (cmd.rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

endmodule

FILE: sv/spk_ram.sv
// generic simple dual-port ram with registered read
// no dependencies; holds the round keys
module spk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 27,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/spk_ctrl.sv
// sequencer for key expansion and the round loop
// depends on spk_pkg and assert_macros.svh
`include "assert_macros.svh"
module spk_ctrl #(
  parameter int ROUND_COUNT = 27,
  parameter int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  logic              key_write,
  output logic              busy,
  output logic              done,
  output spk_pkg::cmd_t     cmd,
  output logic [AW-1:0]     step_idx,
  output logic [AW-1:0]     rk_waddr,
  output logic [AW-1:0]     rk_raddr
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KLOAD = 3'd1;
  localparam logic [2:0] S_KEXP  = 3'd2;
  localparam logic [2:0] S_PREF  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;

  localparam logic [AW-1:0] LAST_IDX = AW'(ROUND_COUNT - 1);
  localparam logic [AW-1:0] LAST_STEP = AW'((ROUND_COUNT > 1) ? ROUND_COUNT - 2 : 0);

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] count;
  logic [AW-1:0] count_next;
  logic          decrypt;
  logic          decrypt_next;
  logic          keys_fresh;
  logic          keys_fresh_next;
  logic          done_next;

  always_comb begin
    state_next      = state;
    count_next      = count;
    decrypt_next    = decrypt;
    keys_fresh_next = keys_fresh;
    done_next       = 1'b0;
    cmd             = '0;
    cmd.decrypt     = decrypt;
    rk_waddr        = '0;
    rk_raddr        = '0;
    step_idx        = count;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_block = 1'b1;
          decrypt_next   = mode;
          state_next     = keys_fresh ? S_PREF : S_KLOAD;
        end
      end
      S_KLOAD: begin
        cmd.key_init = 1'b1;
        cmd.rk_we    = 1'b1;
        count_next   = '0;
        if (ROUND_COUNT > 1) begin
          state_next = S_KEXP;
        end else begin
          keys_fresh_next = 1'b1;
          state_next      = S_PREF;
        end
      end
      S_KEXP: begin
        cmd.key_step = 1'b1;
        cmd.rk_we    = 1'b1;
        rk_waddr     = count + AW'(1);
        if (count == LAST_STEP) begin
          keys_fresh_next = 1'b1;
          state_next      = S_PREF;
        end else begin
          count_next = count + AW'(1);
        end
      end
      S_PREF: begin
        rk_raddr   = decrypt ? LAST_IDX : '0;
        count_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        // fetch the key of the following round in the cycle before it is used
        if (count == LAST_IDX) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          rk_raddr   = decrypt ? (LAST_STEP - count) : (count + AW'(1));
          count_next = count + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (key_write) begin
      keys_fresh_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      decrypt    <= 1'b0;
      keys_fresh <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      decrypt    <= decrypt_next;
      keys_fresh <= keys_fresh_next;
      done       <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  `ASSERT_SAME(a_busy_ends_with_done, clk, rst, $fell(busy), done, "busy fell without a result")
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held for two cycles")
  `ASSERT_NEXT(a_stale_expands, clk, rst, start && !busy && !keys_fresh && !key_write,
               state == S_KLOAD, "stale keys not expanded before rounds")
  `ASSERT_SAME(a_no_write_in_rounds, clk, rst, cmd.round_en, !cmd.rk_we,
               "round key written during rounds")

endmodule

FILE: sv/spk_datapath.sv
// key words, key schedule lanes and the round function
// depends on spk_pkg
module spk_datapath #(
  parameter int ROUND_COUNT = 27,
  parameter int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spk_pkg::cmd_t                cmd,
  input  logic [AW-1:0]                step_idx,
  input  logic                         key_write,
  input  logic [spk_pkg::KSEL_W-1:0]   key_sel,
  input  logic [spk_pkg::WORD_W-1:0]   key_data,
  input  logic [spk_pkg::WORD_W-1:0]   word_low,
  input  logic [spk_pkg::WORD_W-1:0]   word_high,
  input  logic [spk_pkg::WORD_W-1:0]   rk_rdata,
  output logic [spk_pkg::WORD_W-1:0]   rk_wdata,
  output logic [spk_pkg::WORD_W-1:0]   result_low,
  output logic [spk_pkg::WORD_W-1:0]   result_high
);

  localparam int W = spk_pkg::WORD_W;

  logic [W-1:0] key_word [spk_pkg::KEY_WORDS];
  logic [W-1:0] lane [spk_pkg::KEY_WORDS-1];
  logic [W-1:0] kb;
  logic [W-1:0] lane_next;
  logic [W-1:0] kb_next;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] x_next;
  logic [W-1:0] y_next;
  logic [W-1:0] y_mix;

  // one schedule step on the lane at the head of the queue
  always_comb begin
    lane_next = (spk_pkg::ror8(lane[0]) + kb) ^ W'(step_idx);
    kb_next   = spk_pkg::rol3(kb) ^ lane_next;
    rk_wdata  = cmd.key_init ? key_word[0] : kb_next;
  end

  always_comb begin
    if (cmd.decrypt) begin
      y_mix  = spk_pkg::ror3(y ^ x);
      y_next = y_mix;
      x_next = spk_pkg::rol8((x ^ rk_rdata) - y_mix);
    end else begin
      x_next = (spk_pkg::ror8(x) + y) ^ rk_rdata;
      y_mix  = spk_pkg::rol3(y);
      y_next = y_mix ^ x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spk_pkg::KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
    end else if (key_write) begin
      key_word[key_sel] <= key_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      kb <= key_word[0];
      for (int i = 0; i < spk_pkg::KEY_WORDS - 1; i++) begin
        lane[i] <= key_word[i + 1];
      end
    end else if (cmd.key_step) begin
      kb <= kb_next;
      for (int i = 0; i < spk_pkg::KEY_WORDS - 2; i++) begin
        lane[i] <= lane[i + 1];
      end
      lane[spk_pkg::KEY_WORDS-2] <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      x <= word_high;
      y <= word_low;
    end else if (cmd.round_en) begin
      x <= x_next;
      y <= y_next;
    end
  end

  assign result_low  = y;
  assign result_high = x;

endmodule

FILE: tb/sv/speck64_128_block_cipher_tb.sv
// self-checking testbench for the speck 64/128 block cipher top level
// depends on spk_pkg and speck64_128_block_cipher; predicts every block in-line
// runs key phases with directed and random blocks, random gaps on the block input
module speck64_128_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spk_pkg::*;

  localparam int ROUNDS = 27;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_BLOCKS = 100;
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam logic [CFG_IDX_W-1:0] KEY_REGS [KEY_WORDS] =
    '{REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3};

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    logic  mode;
    word_t low;
    word_t high;
  } block_t;

  typedef struct {
    word_t low;
    word_t high;
  } cipher_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode = MODE_ENC;
  word_t                word_low = '0;
  word_t                word_high = '0;
  logic                 done;
  word_t                result_low;
  word_t                result_high;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t                cfg_data = '0;

  // own copy of the key state
  word_t key_words [KEY_WORDS];
  word_t round_keys [ROUNDS];
  bit    keys_valid;

  block_t      pending_blocks [$];
  cipher_out_t expected_results [$];
  int          failures;
  int          gap_pct;
  int          gap_left;
  int          quiet_cycles;
  bit          block_taken;

  speck64_128_block_cipher #(
    .ROUND_COUNT(ROUNDS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .word_low   (word_low),
    .word_high  (word_high),
    .done       (done),
    .result_low (result_low),
    .result_high(result_high),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t rot_r(word_t v, int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rot_l(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // expands the schedule first when the key has been rewritten
  function automatic cipher_out_t speck_transform(block_t b);
    word_t lane [KEY_WORDS-1];
    word_t k;
    word_t x;
    word_t y;
    int    i;
    if (!keys_valid) begin
      for (i = 0; i < KEY_WORDS - 1; i++) lane[i] = key_words[i + 1];
      k = key_words[0];
      round_keys[0] = k;
      for (i = 0; i < ROUNDS - 1; i++) begin
        lane[i % (KEY_WORDS - 1)] =
          (rot_r(lane[i % (KEY_WORDS - 1)], ROT_X) + k) ^ word_t'(i);
        k = rot_l(k, ROT_Y) ^ lane[i % (KEY_WORDS - 1)];
        round_keys[i + 1] = k;
      end
      keys_valid = 1'b1;
    end
    x = b.high;
    y = b.low;
    if (b.mode == MODE_ENC) begin
      for (i = 0; i < ROUNDS; i++) begin
        x = (rot_r(x, ROT_X) + y) ^ round_keys[i];
        y = rot_l(y, ROT_Y) ^ x;
      end
    end else begin
      for (i = 0; i < ROUNDS; i++) begin
        y = rot_r(y ^ x, ROT_Y);
        x = rot_l((x ^ round_keys[ROUNDS - 1 - i]) - y, ROT_X);
      end
    end
    return '{low: y, high: x};
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(1, 4);
    if (k < 9) return $urandom_range(5, 30);
    return $urandom_range(31, 80);
  endfunction

  task automatic queue_block(logic m, word_t lo, word_t hi);
    pending_blocks.push_back('{mode: m, low: lo, high: hi});
  endtask

  // mostly leaves cfg_valid high so that writes can run back to back
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < KEY_WORDS) begin
      key_words[idx] = data;
      keys_valid = 1'b0;
    end
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_blocks.size() != 0 || start || expected_results.size() != 0);
  endtask

  // block driver
  always @(negedge clk) begin
    block_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || block_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        nxt = pending_blocks.pop_front();
        mode      <= nxt.mode;
        word_low  <= nxt.low;
        word_high <= nxt.high;
        start     <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result checker; results are checked before a new word is predicted
  always @(posedge clk) begin
    cipher_out_t want;
    cipher_out_t got;
    if (rst) begin
      block_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (done) begin
        got = '{low: result_low, high: result_high};
        if (expected_results.size() == 0) begin
          $error("unexpected result: result_low %h result_high %h", got.low, got.high);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.low !== want.low) begin
            $error("result_low: expected %h, got %h", want.low, got.low);
            failures++;
          end
          if (got.high !== want.high) begin
            $error("result_high: expected %h, got %h", want.high, got.high);
            failures++;
          end
        end
      end
      block_taken = start && !busy;
      if (block_taken)
        expected_results.push_back(
          speck_transform('{mode: mode, low: word_low, high: word_high}));
      if (done || block_taken || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int    ph;
    int    n;
    int    w;
    word_t kw;
    logic [CFG_IDX_W-1:0] idx;

    for (int i = 0; i < KEY_WORDS; i++) key_words[i] = '0;
    for (int i = 0; i < ROUNDS; i++) round_keys[i] = '0;
    keys_valid = 1'b0;
    failures = 0;
    gap_left = 0;
    gap_pct = 30;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // key left at its reset value
    queue_block(MODE_ENC, '0, '0);
    queue_block(MODE_ENC, '1, '1);
    queue_block(MODE_DEC, '0, '0);
    queue_block(MODE_DEC, '1, '1);
    wait_idle();

    // published test key, then writes to indexes past the key words
    cfg_write(REG_KEY_WORD_0, 32'h0302_0100);
    cfg_write(REG_KEY_WORD_1, 32'h0b0a_0908);
    cfg_write(REG_KEY_WORD_2, 32'h1312_1110);
    cfg_write(REG_KEY_WORD_3, 32'h1b1a_1918);
    cfg_write(CFG_IDX_W'(KEY_WORDS), $urandom);
    cfg_write('1, $urandom);
    cfg_release();
    queue_block(MODE_ENC, 32'h7475_432d, 32'h3b72_6574);
    queue_block(MODE_DEC, 32'h454e_028b, 32'h8c6f_a548);
    queue_block(MODE_ENC, '0, '1);
    queue_block(MODE_DEC, 32'h5555_5555, 32'haaaa_aaaa);
    queue_block(MODE_ENC, 32'h8000_0000, 32'h0000_0001);
    queue_block(MODE_DEC, 32'h7fff_ffff, 32'h8000_0000);
    wait_idle();

    for (int i = 0; i < KEY_WORDS; i++) cfg_write(KEY_REGS[i], '1);
    cfg_release();
    queue_block(MODE_ENC, '0, '0);
    queue_block(MODE_DEC, '1, '0);
    queue_block(MODE_ENC, 32'haaaa_aaaa, 32'h5555_5555);
    queue_block(MODE_DEC, '0, '1);
    wait_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 60;
      endcase
      n = $urandom_range(1, 5);
      for (w = 0; w < n; w++) begin
        if ($urandom_range(0, 4) == 0)
          idx = CFG_IDX_W'($urandom_range(KEY_WORDS, (1 << CFG_IDX_W) - 1));
        else
          idx = KEY_REGS[KSEL_W'($urandom_range(0, KEY_WORDS - 1))];
        case ($urandom_range(0, 6))
          0: kw = '0;
          1: kw = '1;
          default: kw = $urandom;
        endcase
        cfg_write(idx, kw);
      end
      cfg_release();
      for (w = 0; w < PHASE_BLOCKS; w++)
        queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
      wait_idle();
    end

    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/spk_pkg.sv
sv/spk_ram.sv
sv/spk_ctrl.sv
sv/spk_datapath.sv
sv/speck64_128_block_cipher.sv
tb/sv/speck64_128_block_cipher_tb.sv
